// ===== rtl/snr_pkg.sv =====
// Shared types, opcodes and codes of the SPI NOR sector read-modify-write controller.
package snr_pkg;

    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int PAGE_BYTES_DEF   = 256;

    // host modes
    localparam logic [3:0] MODE_REPLY  = 4'd0;
    localparam logic [3:0] MODE_READ   = 4'd1;
    localparam logic [3:0] MODE_WRITE  = 4'd2;
    localparam logic [3:0] MODE_WDATA  = 4'd3;
    localparam logic [3:0] MODE_CERASE = 4'd4;
    localparam logic [3:0] MODE_RID    = 4'd5;
    localparam logic [3:0] MODE_PDOWN  = 4'd6;
    localparam logic [3:0] MODE_WAKE   = 4'd7;
    localparam logic [3:0] MODE_WDIS   = 4'd8;

    // flash opcodes
    localparam logic [7:0] OP_READ   = 8'h03;
    localparam logic [7:0] OP_PP     = 8'h02;
    localparam logic [7:0] OP_WREN   = 8'h06;
    localparam logic [7:0] OP_WRDI   = 8'h04;
    localparam logic [7:0] OP_RDSR   = 8'h05;
    localparam logic [7:0] OP_SE     = 8'h20;
    localparam logic [7:0] OP_CE     = 8'hC7;
    localparam logic [7:0] OP_RID    = 8'h90;
    localparam logic [7:0] OP_PDOWN  = 8'hB9;
    localparam logic [7:0] OP_WAKE   = 8'hAB;
    localparam logic [7:0] DUMMY_FF  = 8'hFF;
    localparam logic [7:0] DUMMY_00  = 8'h00;

    typedef enum logic [3:0] {
        CLS_REPLY,
        CLS_READ,
        CLS_WRITE,
        CLS_WDATA,
        CLS_CERASE,
        CLS_RID,
        CLS_PDOWN,
        CLS_WAKE,
        CLS_WDIS,
        CLS_BAD
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  byte_value;
    } cmd_t;

    typedef enum logic [2:0] {
        K_FRAME = 3'd0,
        K_READ  = 3'd1,
        K_ID    = 3'd2,
        K_REQ   = 3'd3,
        K_DONE  = 3'd4,
        K_REJ   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  spi_byte;
        logic        select_end;
        logic [15:0] value;
        logic        last;
    } res_t;

    typedef enum logic [12:0] {
        PH_IDLE    = 13'h0001,
        PH_SIMPLE  = 13'h0002,
        PH_RID     = 13'h0004,
        PH_READ    = 13'h0008,
        PH_SREAD   = 13'h0010,
        PH_DATA    = 13'h0020,
        PH_WREN_CE = 13'h0040,
        PH_WREN_SE = 13'h0080,
        PH_WREN_PP = 13'h0100,
        PH_POLL    = 13'h0200,
        PH_CE      = 13'h0400,
        PH_SE      = 13'h0800,
        PH_PP      = 13'h1000
    } phase_t;

    typedef enum logic [4:0] {
        RET_CE        = 5'b00001,
        RET_SE        = 5'b00010,
        RET_DONE      = 5'b00100,
        RET_ERASED    = 5'b01000,
        RET_PAGE_DONE = 5'b10000
    } ret_t;

endpackage

// ===== rtl/snr_ifs.sv =====
// Valid/ready channel interfaces for host commands and results.
interface snr_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  byte_value;

    modport source (output valid, output mode, output address, output length,
                    output byte_value, input ready);
    modport sink (input valid, input mode, input address, input length,
                  input byte_value, output ready);
endinterface

interface snr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  spi_byte;
    logic        select_end;
    logic [15:0] value;
    logic        last;

    modport source (output valid, output kind, output spi_byte, output select_end,
                    output value, output last, input ready);
    modport sink (input valid, input kind, input spi_byte, input select_end,
                  input value, input last, output ready);
endinterface

// ===== rtl/snr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module snr_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/snr_fifo.sv =====
// Small register queue between the command front end and the sequencer.
module snr_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] head_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full       = (cnt_reg == NW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = slot_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/snr_front.sv =====
// Front end: accept host items, classify the mode and queue them for the sequencer.
module snr_front (
    input  logic             clk,
    input  logic             rst_n,
    snr_in_if.sink           cmd,
    input  logic             pop,
    output logic             head_valid,
    output snr_pkg::cmd_t    head
);

    snr_pkg::cmd_t                      item;
    logic                               full;
    logic [$bits(snr_pkg::cmd_t)-1:0]   head_bits;

    always_comb
    begin
        item.address    = cmd.address;
        item.length     = cmd.length;
        item.byte_value = cmd.byte_value;
        unique case (cmd.mode)
            snr_pkg::MODE_REPLY:  item.cls = snr_pkg::CLS_REPLY;
            snr_pkg::MODE_READ:   item.cls = snr_pkg::CLS_READ;
            // a zero-length write is refused outright
            snr_pkg::MODE_WRITE:  item.cls = (cmd.length == '0) ? snr_pkg::CLS_BAD
                                                                : snr_pkg::CLS_WRITE;
            snr_pkg::MODE_WDATA:  item.cls = snr_pkg::CLS_WDATA;
            snr_pkg::MODE_CERASE: item.cls = snr_pkg::CLS_CERASE;
            snr_pkg::MODE_RID:    item.cls = snr_pkg::CLS_RID;
            snr_pkg::MODE_PDOWN:  item.cls = snr_pkg::CLS_PDOWN;
            snr_pkg::MODE_WAKE:   item.cls = snr_pkg::CLS_WAKE;
            snr_pkg::MODE_WDIS:   item.cls = snr_pkg::CLS_WDIS;
            default:              item.cls = snr_pkg::CLS_BAD;
        endcase
    end

    assign cmd.ready = !full;
    assign head      = snr_pkg::cmd_t'(head_bits);

    snr_fifo #(
        .W     ($bits(snr_pkg::cmd_t)),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd.valid),
        .push_data  (item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_bits)
    );

endmodule

// ===== rtl/snr_back.sv =====
// Back end: command sequencer with sector buffer and result output stage.
module snr_back #(
    parameter int SECTOR_BYTES = snr_pkg::SECTOR_BYTES_DEF,
    parameter int PAGE_BYTES   = snr_pkg::PAGE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  snr_pkg::cmd_t  head,
    output logic           pop,
    snr_out_if.source      rsp
);

    localparam int OW  = $clog2(SECTOR_BYTES);
    localparam int CW  = OW + 1;
    localparam int PB  = $clog2(PAGE_BYTES);
    localparam int PW  = PB + 1;
    localparam int FW  = ($clog2(SECTOR_BYTES + 5) > 17) ? $clog2(SECTOR_BYTES + 5) : 17;
    localparam int XW  = FW + 1;
    localparam logic [XW-1:0] SREAD_TOTAL = XW'(SECTOR_BYTES + 4);

    typedef enum logic [3:0] {
        T_NONE, T_DONE, T_POLL, T_WREN_CE, T_WREN_SE, T_WREN_PP,
        T_CE, T_SE, T_PP, T_SREAD, T_ERASED, T_PAGE_DONE
    } tgt_t;

    snr_pkg::phase_t phase_reg, phase_next;
    snr_pkg::ret_t   ret_reg, ret_next;
    logic [23:0]     cur_reg, cur_next;
    logic [15:0]     remain_reg, remain_next;
    logic [OW-1:0]   seg_off_reg, seg_off_next;
    logic [CW-1:0]   seg_cnt_reg, seg_cnt_next;
    logic [FW-1:0]   fidx_reg, fidx_next;
    logic            nb_reg, nb_next;
    logic [7:0]      idhi_reg, idhi_next;
    logic [CW-1:0]   poff_reg, poff_next;
    logic [CW-1:0]   pleft_reg, pleft_next;
    logic [PW-1:0]   chunk_reg, chunk_next;

    logic            obv_reg, obv_next;
    logic            two_reg, two_next;
    logic            idx_reg, idx_next;
    snr_pkg::res_t   r0_reg, r0_next;
    snr_pkg::res_t   r1_reg, r1_next;

    logic            slot_free, take;
    tgt_t            tgt;
    logic            pre_v, add_v;
    snr_pkg::res_t   pre, add;
    logic [23:0]     base, paddr;
    logic [XW-1:0]   nx, total;
    logic [OW-1:0]   d;
    logic [CW:0]     seg_end;
    logic [PW-1:0]   room_p;
    logic [CW-1:0]   room_s;
    logic [23:0]     new_cur;
    logic [15:0]     new_remain;
    logic [CW-1:0]   new_pleft;
    logic            we;
    logic [OW-1:0]   waddr, raddr;
    logic [7:0]      wdata, rdata;
    logic [FW-1:0]   rsum;

    function automatic snr_pkg::res_t mk(snr_pkg::kind_t k, logic [7:0] sb, logic se,
                                         logic [15:0] v);
        snr_pkg::res_t r;
        r.kind       = k;
        r.spi_byte   = sb;
        r.select_end = se;
        r.value      = v;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] hdr(logic [7:0] op, logic [23:0] a, logic [1:0] i);
        logic [7:0] b;
        unique case (i)
            2'd0:    b = op;
            2'd1:    b = a[23:16];
            2'd2:    b = a[15:8];
            default: b = a[7:0];
        endcase
        return b;
    endfunction

    // bytes of the segment that fit in the sector from this offset on
    function automatic logic [CW-1:0] seg_len(logic [OW-1:0] off, logic [15:0] rem);
        logic [CW-1:0] room;
        room = CW'(SECTOR_BYTES) - {1'b0, off};
        return (18'(rem) < 18'(room)) ? CW'(rem) : room;
    endfunction

    assign base  = {cur_reg[23:OW], OW'(0)};
    assign paddr = {cur_reg[23:OW], poff_reg[OW-1:0]};

    assign slot_free = !obv_reg || (rsp.ready && (!two_reg || idx_reg));
    assign take      = head_valid && slot_free;
    assign pop       = take;

    always_comb
    begin
        phase_next   = phase_reg;
        ret_next     = ret_reg;
        cur_next     = cur_reg;
        remain_next  = remain_reg;
        seg_off_next = seg_off_reg;
        seg_cnt_next = seg_cnt_reg;
        fidx_next    = fidx_reg;
        nb_next      = nb_reg;
        idhi_next    = idhi_reg;
        poff_next    = poff_reg;
        pleft_next   = pleft_reg;
        chunk_next   = chunk_reg;
        tgt          = T_NONE;
        pre_v        = 1'b0;
        pre          = mk(snr_pkg::K_REJ, 8'd0, 1'b0, 16'd0);
        add_v        = 1'b0;
        add          = mk(snr_pkg::K_REJ, 8'd0, 1'b0, 16'd0);
        we           = 1'b0;
        waddr        = '0;
        wdata        = head.byte_value;
        nx           = XW'(fidx_reg) + 1'b1;
        total        = '0;
        d            = OW'(fidx_reg - FW'(4));
        seg_end      = {1'b0, seg_off_reg} + {1'b0, seg_cnt_reg};
        room_p       = PW'(PAGE_BYTES) - {1'b0, poff_reg[PB-1:0]};
        room_s       = '0;
        new_cur      = cur_reg;
        new_remain   = remain_reg;
        new_pleft    = pleft_reg;

        if (take)
        begin
            if (phase_reg == snr_pkg::PH_IDLE)
            begin
                unique case (head.cls)
                    snr_pkg::CLS_READ:
                    begin
                        cur_next    = head.address;
                        remain_next = head.length;
                        phase_next  = snr_pkg::PH_READ;
                        fidx_next   = '0;
                        pre_v       = 1'b1;
                        pre         = mk(snr_pkg::K_FRAME, snr_pkg::OP_READ, 1'b0, 16'd0);
                    end
                    snr_pkg::CLS_WRITE:
                    begin
                        cur_next     = head.address;
                        remain_next  = head.length;
                        seg_off_next = head.address[OW-1:0];
                        seg_cnt_next = seg_len(head.address[OW-1:0], head.length);
                        tgt          = T_SREAD;
                    end
                    snr_pkg::CLS_CERASE: tgt = T_WREN_CE;
                    snr_pkg::CLS_RID:
                    begin
                        phase_next = snr_pkg::PH_RID;
                        fidx_next  = '0;
                        pre_v      = 1'b1;
                        pre        = mk(snr_pkg::K_FRAME, snr_pkg::OP_RID, 1'b0, 16'd0);
                    end
                    snr_pkg::CLS_PDOWN, snr_pkg::CLS_WAKE, snr_pkg::CLS_WDIS:
                    begin
                        phase_next = snr_pkg::PH_SIMPLE;
                        pre_v      = 1'b1;
                        pre        = mk(snr_pkg::K_FRAME,
                                        (head.cls == snr_pkg::CLS_PDOWN) ? snr_pkg::OP_PDOWN :
                                        (head.cls == snr_pkg::CLS_WAKE)  ? snr_pkg::OP_WAKE :
                                                                           snr_pkg::OP_WRDI,
                                        1'b1, 16'd0);
                    end
                    default:
                    begin
                        pre_v = 1'b1;
                    end
                endcase
            end
            else if (phase_reg == snr_pkg::PH_DATA)
            begin
                if (head.cls != snr_pkg::CLS_WDATA)
                begin
                    pre_v = 1'b1;
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = seg_off_reg + fidx_reg[OW-1:0];
                    fidx_next = fidx_reg + 1'b1;
                    if (fidx_next < FW'(seg_cnt_reg))
                    begin
                        tgt = T_NONE;
                    end
                    else if (nb_reg)
                    begin
                        tgt = T_WREN_SE;
                    end
                    else
                    begin
                        poff_next  = CW'(seg_off_reg);
                        pleft_next = seg_cnt_reg;
                        tgt        = T_WREN_PP;
                    end
                end
            end
            else if (head.cls != snr_pkg::CLS_REPLY)
            begin
                pre_v = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    snr_pkg::PH_SIMPLE:  tgt = T_DONE;
                    snr_pkg::PH_WREN_CE:
                    begin
                        ret_next = snr_pkg::RET_CE;
                        tgt      = T_POLL;
                    end
                    snr_pkg::PH_WREN_SE:
                    begin
                        ret_next = snr_pkg::RET_SE;
                        tgt      = T_POLL;
                    end
                    snr_pkg::PH_WREN_PP: tgt = T_PP;
                    snr_pkg::PH_CE:
                    begin
                        ret_next = snr_pkg::RET_DONE;
                        tgt      = T_POLL;
                    end
                    snr_pkg::PH_POLL:
                    begin
                        if (fidx_reg == '0)
                        begin
                            fidx_next = FW'(1);
                            pre_v     = 1'b1;
                            pre       = mk(snr_pkg::K_FRAME, snr_pkg::DUMMY_FF, 1'b1, 16'd0);
                        end
                        else if (head.byte_value[0])
                        begin
                            tgt = T_POLL;
                        end
                        else
                        begin
                            unique case (ret_reg)
                                snr_pkg::RET_CE:     tgt = T_CE;
                                snr_pkg::RET_SE:     tgt = T_SE;
                                snr_pkg::RET_ERASED: tgt = T_ERASED;
                                snr_pkg::RET_PAGE_DONE: tgt = T_PAGE_DONE;
                                default:             tgt = T_DONE;
                            endcase
                        end
                    end
                    snr_pkg::PH_RID:
                    begin
                        if (fidx_reg == FW'(4))
                        begin
                            idhi_next = head.byte_value;
                        end
                        if (fidx_reg >= FW'(5))
                        begin
                            pre_v = 1'b1;
                            pre   = mk(snr_pkg::K_ID, 8'd0, 1'b0, {idhi_reg, head.byte_value});
                            tgt   = T_DONE;
                        end
                        else
                        begin
                            fidx_next = FW'(nx);
                            pre_v     = 1'b1;
                            pre       = mk(snr_pkg::K_FRAME,
                                           (nx < XW'(4)) ? snr_pkg::DUMMY_00 : snr_pkg::DUMMY_FF,
                                           nx == XW'(5), 16'd0);
                        end
                    end
                    snr_pkg::PH_READ:
                    begin
                        total = XW'(remain_reg) + XW'(4);
                        if (fidx_reg >= FW'(4))
                        begin
                            pre_v = 1'b1;
                            pre   = mk(snr_pkg::K_READ, 8'd0, 1'b0, {8'd0, head.byte_value});
                        end
                        if (nx < total)
                        begin
                            fidx_next = FW'(nx);
                            add_v     = 1'b1;
                            add       = mk(snr_pkg::K_FRAME,
                                           (nx < XW'(4)) ? hdr(snr_pkg::OP_READ, cur_reg, nx[1:0])
                                                         : snr_pkg::DUMMY_FF,
                                           nx == total - 1'b1, 16'd0);
                        end
                        else
                        begin
                            tgt = T_DONE;
                        end
                    end
                    snr_pkg::PH_SREAD:
                    begin
                        if (fidx_reg >= FW'(4))
                        begin
                            we    = 1'b1;
                            waddr = d;
                            if (d >= seg_off_reg && {1'b0, 1'b0, d} < seg_end
                                && head.byte_value != snr_pkg::DUMMY_FF)
                            begin
                                nb_next = 1'b1;
                            end
                        end
                        pre_v = 1'b1;
                        if (nx < SREAD_TOTAL)
                        begin
                            fidx_next = FW'(nx);
                            pre       = mk(snr_pkg::K_FRAME,
                                           (nx < XW'(4)) ? hdr(snr_pkg::OP_READ, base, nx[1:0])
                                                         : snr_pkg::DUMMY_FF,
                                           nx == SREAD_TOTAL - 1'b1, 16'd0);
                        end
                        else
                        begin
                            phase_next = snr_pkg::PH_DATA;
                            fidx_next  = '0;
                            pre        = mk(snr_pkg::K_REQ, 8'd0, 1'b0, 16'(seg_cnt_reg));
                        end
                    end
                    snr_pkg::PH_SE:
                    begin
                        if (fidx_reg < FW'(3))
                        begin
                            fidx_next = FW'(nx);
                            pre_v     = 1'b1;
                            pre       = mk(snr_pkg::K_FRAME, hdr(snr_pkg::OP_SE, base, nx[1:0]),
                                           nx == XW'(3), 16'd0);
                        end
                        else
                        begin
                            ret_next = snr_pkg::RET_ERASED;
                            tgt      = T_POLL;
                        end
                    end
                    snr_pkg::PH_PP:
                    begin
                        total = XW'(chunk_reg) + XW'(4);
                        if (nx < total)
                        begin
                            fidx_next = FW'(nx);
                            pre_v     = 1'b1;
                            // data bytes come from the prefetched buffer read
                            pre       = mk(snr_pkg::K_FRAME,
                                           (nx < XW'(4)) ? hdr(snr_pkg::OP_PP, paddr, nx[1:0])
                                                         : rdata,
                                           nx == total - 1'b1, 16'd0);
                        end
                        else
                        begin
                            ret_next = snr_pkg::RET_PAGE_DONE;
                            tgt      = T_POLL;
                        end
                    end
                    default:
                    begin
                        pre_v = 1'b1;
                    end
                endcase
            end

            // enter the next phase, appending its opening result
            unique case (tgt)
                T_NONE: add_v = add_v;
                T_DONE:
                begin
                    phase_next = snr_pkg::PH_IDLE;
                    add_v      = 1'b1;
                    add        = mk(snr_pkg::K_DONE, 8'd0, 1'b0, 16'd0);
                end
                T_POLL:
                begin
                    phase_next = snr_pkg::PH_POLL;
                    fidx_next  = '0;
                    add_v      = 1'b1;
                    add        = mk(snr_pkg::K_FRAME, snr_pkg::OP_RDSR, 1'b0, 16'd0);
                end
                T_WREN_CE, T_WREN_SE, T_WREN_PP:
                begin
                    phase_next = (tgt == T_WREN_CE) ? snr_pkg::PH_WREN_CE :
                                 (tgt == T_WREN_SE) ? snr_pkg::PH_WREN_SE : snr_pkg::PH_WREN_PP;
                    add_v      = 1'b1;
                    add        = mk(snr_pkg::K_FRAME, snr_pkg::OP_WREN, 1'b1, 16'd0);
                end
                T_CE:
                begin
                    phase_next = snr_pkg::PH_CE;
                    add_v      = 1'b1;
                    add        = mk(snr_pkg::K_FRAME, snr_pkg::OP_CE, 1'b1, 16'd0);
                end
                T_SE:
                begin
                    phase_next = snr_pkg::PH_SE;
                    fidx_next  = '0;
                    add_v      = 1'b1;
                    add        = mk(snr_pkg::K_FRAME, snr_pkg::OP_SE, 1'b0, 16'd0);
                end
                T_PP:
                begin
                    chunk_next = (pleft_reg < CW'(room_p)) ? PW'(pleft_reg) : room_p;
                    phase_next = snr_pkg::PH_PP;
                    fidx_next  = '0;
                    add_v      = 1'b1;
                    add        = mk(snr_pkg::K_FRAME, snr_pkg::OP_PP, 1'b0, 16'd0);
                end
                T_SREAD:
                begin
                    phase_next = snr_pkg::PH_SREAD;
                    fidx_next  = '0;
                    nb_next    = 1'b0;
                    add_v      = 1'b1;
                    add        = mk(snr_pkg::K_FRAME, snr_pkg::OP_READ, 1'b0, 16'd0);
                end
                T_ERASED:
                begin
                    poff_next  = '0;
                    pleft_next = CW'(SECTOR_BYTES);
                    phase_next = snr_pkg::PH_WREN_PP;
                    add_v      = 1'b1;
                    add        = mk(snr_pkg::K_FRAME, snr_pkg::OP_WREN, 1'b1, 16'd0);
                end
                default:
                begin
                    // page finished: next page, next sector, or done
                    poff_next  = poff_reg + CW'(chunk_reg);
                    new_pleft  = pleft_reg - CW'(chunk_reg);
                    pleft_next = new_pleft;
                    add_v      = 1'b1;
                    if (new_pleft != '0)
                    begin
                        phase_next = snr_pkg::PH_WREN_PP;
                        add        = mk(snr_pkg::K_FRAME, snr_pkg::OP_WREN, 1'b1, 16'd0);
                    end
                    else
                    begin
                        new_remain  = remain_reg - 16'(seg_cnt_reg);
                        new_cur     = cur_reg + 24'(seg_cnt_reg);
                        remain_next = new_remain;
                        cur_next    = new_cur;
                        if (new_remain == '0)
                        begin
                            phase_next = snr_pkg::PH_IDLE;
                            add        = mk(snr_pkg::K_DONE, 8'd0, 1'b0, 16'd0);
                        end
                        else
                        begin
                            room_s       = seg_len(new_cur[OW-1:0], new_remain);
                            seg_off_next = new_cur[OW-1:0];
                            seg_cnt_next = room_s;
                            phase_next   = snr_pkg::PH_SREAD;
                            fidx_next    = '0;
                            nb_next      = 1'b0;
                            add          = mk(snr_pkg::K_FRAME, snr_pkg::OP_READ, 1'b0, 16'd0);
                        end
                    end
                end
            endcase
        end
    end

    // prefetch the buffer byte the next page-program reply will need
    assign rsum  = FW'(poff_next) + fidx_next - FW'(3);
    assign raddr = rsum[OW-1:0];

    snr_ram #(
        .W     (8),
        .DEPTH (SECTOR_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // output stage: hold up to two results of one item, send them in order
    always_comb
    begin
        obv_next = obv_reg;
        two_next = two_reg;
        idx_next = idx_reg;
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        if (obv_reg && rsp.ready)
        begin
            if (two_reg && !idx_reg)
            begin
                idx_next = 1'b1;
            end
            else
            begin
                obv_next = 1'b0;
            end
        end
        if (take && (pre_v || add_v))
        begin
            obv_next = 1'b1;
            idx_next = 1'b0;
            two_next = pre_v && add_v;
            r0_next  = pre_v ? pre : add;
            r0_next.last = !(pre_v && add_v);
            r1_next  = add;
            r1_next.last = 1'b1;
        end
    end

    assign rsp.valid      = obv_reg;
    assign rsp.kind       = idx_reg ? r1_reg.kind : r0_reg.kind;
    assign rsp.spi_byte   = idx_reg ? r1_reg.spi_byte : r0_reg.spi_byte;
    assign rsp.select_end = idx_reg ? r1_reg.select_end : r0_reg.select_end;
    assign rsp.value      = idx_reg ? r1_reg.value : r0_reg.value;
    assign rsp.last       = idx_reg ? r1_reg.last : r0_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= snr_pkg::PH_IDLE;
            ret_reg     <= snr_pkg::RET_DONE;
            cur_reg     <= '0;
            remain_reg  <= '0;
            seg_off_reg <= '0;
            seg_cnt_reg <= '0;
            fidx_reg    <= '0;
            nb_reg      <= 1'b0;
            idhi_reg    <= '0;
            poff_reg    <= '0;
            pleft_reg   <= '0;
            chunk_reg   <= '0;
            obv_reg     <= 1'b0;
            two_reg     <= 1'b0;
            idx_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            ret_reg     <= ret_next;
            cur_reg     <= cur_next;
            remain_reg  <= remain_next;
            seg_off_reg <= seg_off_next;
            seg_cnt_reg <= seg_cnt_next;
            fidx_reg    <= fidx_next;
            nb_reg      <= nb_next;
            idhi_reg    <= idhi_next;
            poff_reg    <= poff_next;
            pleft_reg   <= pleft_next;
            chunk_reg   <= chunk_next;
            obv_reg     <= obv_next;
            two_reg     <= two_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

endmodule

// ===== rtl/spi_nor_flash_sector_rmw_controller_unit.sv =====
// Items queue in the front end; each item's first result is registered at the output.
// One item per cycle unless rsp stalls; an item's two results hold the port until both leave.
// The sequencer step and the sector buffer read port (prefetched one step ahead) set this rate.
// Reset: all sequencer state clears at once; no clearing pass, the sector buffer is
// undefined until the sector read fills it.
module spi_nor_flash_sector_rmw_controller_unit #(
    parameter int SECTOR_BYTES = snr_pkg::SECTOR_BYTES_DEF,
    parameter int PAGE_BYTES   = snr_pkg::PAGE_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    snr_in_if.sink    cmd,
    snr_out_if.source rsp
);

    logic          pop;
    logic          head_valid;
    snr_pkg::cmd_t head;

    snr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    snr_back #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule
